FILE: src/range_mode_query_core_assert.svh
`ifndef RANGE_MODE_QUERY_CORE_ASSERT_SVH
`define RANGE_MODE_QUERY_CORE_ASSERT_SVH
// Concurrent check on clk_i, disabled while rst_ni is low.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Implication check: when cond holds, expr must hold in the same cycle.
`define RMQ_ASSERT_IMP(lbl, cond, expr, msg) \
  `RMQ_ASSERT(lbl, (cond) |-> (expr), msg)
`endif

FILE: src/rmq_pkg.sv
`default_nettype none
package rmq_pkg;
  localparam int unsigned DefDepth = 4096;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned PosW     = 13;
  localparam int unsigned ValW     = 32;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRD,
    ST_CWT,
    ST_SCAN,
    ST_LAST,
    ST_UPD
  } rmq_state_e;
endpackage
`default_nettype wire

FILE: src/rmq_if.sv
`default_nettype none
interface rmq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [rmq_pkg::AddrW-1:0]        element_address;
  logic signed [rmq_pkg::ValW-1:0]  element_value;
  logic [rmq_pkg::PosW-1:0]         range_start;
  logic [rmq_pkg::PosW-1:0]         range_end;
  modport source (output valid, mode, element_address, element_value, range_start,
                  range_end, input ready);
  modport sink (input valid, mode, element_address, element_value, range_start,
                range_end, output ready);
endinterface

interface rmq_out_if;
  logic                             valid;
  logic                             ready;
  logic [rmq_pkg::PosW-1:0]         top_frequency;
  logic signed [rmq_pkg::ValW-1:0]  most_common_value;
  logic                             range_error;
  modport source (output valid, top_frequency, most_common_value, range_error,
                  input ready);
  modport sink (input valid, top_frequency, most_common_value, range_error,
                output ready);
endinterface
`default_nettype wire

FILE: src/rmq_ram.sv
`default_nettype none
module rmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: src/range_mode_query_core.sv
// Loads write the element memory when accepted. In a query over n elements
// every element of the range is a candidate and the range is rescanned through
// the single read port of the element memory, one element per cycle.
// Error and empty-range queries answer without a scan. One item at a time.
// Reset (rst_ni low, asynchronous) clears control state; memory is not cleared.
`default_nettype none
`include "range_mode_query_core_assert.svh"
module range_mode_query_core #(
  parameter int unsigned Depth = rmq_pkg::DefDepth
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  rmq_in_if.sink     in_i,
  rmq_out_if.source  out_o
);
  import rmq_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;

  rmq_state_e state_q, state_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic [ValW-1:0] cand_q, cand_d, best_val_q, best_val_d;
  logic [CW-1:0] cnt_q, cnt_d, best_cnt_q, best_cnt_d;
  logic pend_q, pend_d;
  logic ovld_q, ovld_d, oerr_q, oerr_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [ValW-1:0] oval_q, oval_d;

  logic acc, we;
  logic [AW-1:0] raddr;
  logic [ValW-1:0] rdata;
  logic [CW-1:0] cnt_hit;
  logic better;

  // Input is taken only when idle and the result register is free.
  assign in_i.ready = (state_q == ST_IDLE) && (!ovld_q || out_o.ready);
  assign acc = in_i.valid && in_i.ready;
  assign we = acc && (in_i.mode == ModeLoad) &&
              ({20'd0, in_i.element_address} < 32'(Depth));

  rmq_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(in_i.element_address)),
    .wdata_i (in_i.element_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read address: the candidate first, then the scan position.
  always_comb begin
    case (state_q)
      ST_CRD:  raddr = i_q;
      default: raddr = j_q;
    endcase
  end

  assign cnt_hit = cnt_q + CW'(rdata == cand_q);
  assign better = (cnt_q > best_cnt_q) ||
                  ((cnt_q == best_cnt_q) && ($signed(cand_q) < $signed(best_val_q)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_i.mode == ModeQuery && in_i.range_start != '0 &&
            {19'd0, in_i.range_end} <= 32'(Depth) &&
            in_i.range_end >= in_i.range_start) begin
          state_d = ST_CRD;
        end
      end
      ST_CRD:  state_d = ST_CWT;
      ST_CWT:  state_d = ST_SCAN;
      ST_SCAN: if (j_q == hi_q) state_d = ST_LAST;
      ST_LAST: state_d = ST_UPD;
      ST_UPD:  state_d = (i_q == hi_q) ? ST_IDLE : ST_CRD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    lo_d = lo_q; hi_d = hi_q; i_d = i_q; j_d = j_q;
    cand_d = cand_q; cnt_d = cnt_q; pend_d = 1'b0;
    best_cnt_d = best_cnt_q; best_val_d = best_val_q;
    ovld_d = ovld_q && !out_o.ready;
    oerr_d = oerr_q; ocnt_d = ocnt_q; oval_d = oval_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_i.mode == ModeQuery) begin
          lo_d = AW'(in_i.range_start - PosW'(1));
          hi_d = AW'(in_i.range_end - PosW'(1));
          i_d = AW'(in_i.range_start - PosW'(1));
          best_cnt_d = '0;
          best_val_d = '0;
          if (in_i.range_start == '0 || {19'd0, in_i.range_end} > 32'(Depth)) begin
            ovld_d = 1'b1; oerr_d = 1'b1; ocnt_d = '0; oval_d = '0;
          end else if (in_i.range_end < in_i.range_start) begin
            ovld_d = 1'b1; oerr_d = 1'b0; ocnt_d = '0; oval_d = '0;
          end
        end
      end
      ST_CWT: begin
        cand_d = rdata;
        cnt_d = '0;
        j_d = lo_q;
      end
      ST_SCAN: begin
        pend_d = 1'b1;
        if (pend_q) cnt_d = cnt_hit;
        if (j_q != hi_q) j_d = j_q + AW'(1);
      end
      ST_LAST: cnt_d = cnt_hit;
      ST_UPD: begin
        if (better) begin
          best_cnt_d = cnt_q;
          best_val_d = cand_q;
        end
        if (i_q == hi_q) begin
          ovld_d = 1'b1;
          oerr_d = 1'b0;
          ocnt_d = better ? cnt_q : best_cnt_q;
          oval_d = better ? cand_q : best_val_q;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d; j_q <= j_d;
    cand_q <= cand_d; cnt_q <= cnt_d;
    best_cnt_q <= best_cnt_d; best_val_q <= best_val_d;
    oerr_q <= oerr_d; ocnt_q <= ocnt_d; oval_q <= oval_d;
  end

  assign out_o.valid = ovld_q;
  assign out_o.top_frequency = PosW'(ocnt_q);
  assign out_o.most_common_value = oval_q;
  assign out_o.range_error = oerr_q;

  `RMQ_ASSERT_IMP(a_err_zero, ovld_q && oerr_q, ocnt_q == '0 && oval_q == '0,
                  "error with data")
  `RMQ_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, j_q >= lo_q && j_q <= hi_q,
                  "scan out of range")
  `RMQ_ASSERT(a_start_query,
              (state_q == ST_IDLE && state_d != ST_IDLE) |-> (acc && in_i.mode == ModeQuery),
              "bad start")
  `RMQ_ASSERT(a_busy_hold, (state_q != ST_IDLE) |-> !in_i.ready, "ready while busy")
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rmq_pkg::*;

  localparam int unsigned Depth     = DefDepth;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned NumRandom = 60;

  // One expected query answer.
  typedef struct {
    logic [PosW-1:0]        freq;
    logic signed [ValW-1:0] value;
    logic                   err;
  } answer_t;

  // One row of the directed table.
  typedef struct {
    logic                   mode;
    logic [AddrW-1:0]       addr;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        first;
    logic [PosW-1:0]        last;
    bit                     typed;
    answer_t                answer;
  } row_t;

  logic clk;
  logic rst_n;

  rmq_in_if  in_bus ();
  rmq_out_if out_bus ();

  range_mode_query_core #(.Depth(Depth)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  logic signed [ValW-1:0] elements[Depth];
  bit                     loaded[Depth];
  answer_t                pending_answers[$];
  int                     fail_count;
  bit                     long_hold;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Most frequent value over a 1-based inclusive range, smallest value on a tie.
  function automatic answer_t range_mode(input logic [PosW-1:0] first,
                                         input logic [PosW-1:0] last);
    answer_t a;
    int      cnt;
    a.freq  = '0;
    a.value = '0;
    a.err   = 1'b0;
    if (first == 0 || last > Depth) begin
      a.err = 1'b1;
    end else if (last >= first) begin
      for (int k = first - 1; k < last; k++) begin
        cnt = 0;
        for (int j = first - 1; j < last; j++) begin
          if (elements[j] == elements[k]) cnt++;
        end
        if (cnt > a.freq || (cnt == a.freq && elements[k] < a.value)) begin
          a.freq  = cnt[PosW-1:0];
          a.value = elements[k];
        end
      end
    end
    return a;
  endfunction

  // Offer one word after a random gap and wait until it is taken.
  task automatic offer_word(input row_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.mode            <= r.mode;
    in_bus.element_address <= r.addr;
    in_bus.element_value   <= r.value;
    in_bus.range_start     <= r.first;
    in_bus.range_end       <= r.last;
    do @(posedge clk); while (!in_bus.ready);
    if (r.mode == ModeLoad) begin
      elements[r.addr] = r.value;
      loaded[r.addr]   = 1'b1;
    end else if (r.typed) begin
      pending_answers.push_back(r.answer);
    end else begin
      pending_answers.push_back(range_mode(r.first, r.last));
    end
  endtask

  function automatic row_t load_row(input int addr, input logic signed [ValW-1:0] v);
    row_t r;
    r       = '{default: '0};
    r.mode  = ModeLoad;
    r.addr  = addr[AddrW-1:0];
    r.value = v;
    r.first = PosW'($urandom());
    r.last  = PosW'($urandom());
    return r;
  endfunction

  function automatic row_t query_row(input int first, input int last, input bit typed,
                                     input int freq, input logic signed [ValW-1:0] v,
                                     input bit err);
    row_t r;
    r        = '{default: '0};
    r.mode   = ModeQuery;
    r.addr   = AddrW'($urandom());
    r.value  = $signed($urandom());
    r.first  = first[PosW-1:0];
    r.last   = last[PosW-1:0];
    r.typed  = typed;
    r.answer = '{freq: freq[PosW-1:0], value: v, err: err};
    return r;
  endfunction

  // Random query that only reads loaded elements, or an error or empty range.
  function automatic row_t random_query();
    int first;
    int last;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return query_row(0, $urandom_range(0, 8191), 0, 0, 0, 0);
    if (pick == 1) return query_row($urandom_range(0, 8191), $urandom_range(Depth + 1, 8191),
                                    0, 0, 0, 0);
    if (pick == 2) begin
      first = $urandom_range(1, 8191);
      return query_row(first, $urandom_range(0, first - 1), 0, 0, 0, 0);
    end
    first = $urandom_range(1, 64);
    last  = first + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 11));
    for (int k = first; k <= last; k++) begin
      if (k > Depth || !loaded[k-1]) begin
        last = k - 1;
        break;
      end
    end
    return query_row(first, last, 0, 0, 0, 0);
  endfunction

  // Values from a narrow pool, so that counts and ties occur often.
  function automatic logic signed [ValW-1:0] pool_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // Result side: random stalls, one long hold on request, field checks.
  initial begin
    answer_t want;
    int      stall;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      if (pending_answers.size() == 0) begin
        $error("result word with no query waiting");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_bus.top_frequency !== want.freq) begin
          $error("top_frequency: expected %0d, got %0d", want.freq, out_bus.top_frequency);
          fail_count++;
        end
        if (out_bus.most_common_value !== want.value) begin
          $error("most_common_value: expected %0d, got %0d", want.value,
                 out_bus.most_common_value);
          fail_count++;
        end
        if (out_bus.range_error !== want.err) begin
          $error("range_error: expected %0d, got %0d", want.err, out_bus.range_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("FAIL range_mode_query_core");
        $finish;
      end
    end
  end

  // Stimulus: directed table, preload, random words, then drain.
  initial begin
    row_t directed[$];
    row_t r;
    fail_count             = 0;
    long_hold              = 1'b0;
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.mode            = ModeLoad;
    in_bus.element_address = '0;
    in_bus.element_value   = '0;
    in_bus.range_start     = '0;
    in_bus.range_end       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(load_row(0, 32'sh8000_0000));
    directed.push_back(load_row(1, 32'sh7fff_ffff));
    directed.push_back(load_row(2, 32'sh8000_0000));
    directed.push_back(load_row(3, 5));
    directed.push_back(load_row(4, 5));
    directed.push_back(load_row(Depth - 1, 7));
    directed.push_back(query_row(1, 1, 1, 1, 32'sh8000_0000, 0));
    directed.push_back(query_row(1, 3, 1, 2, 32'sh8000_0000, 0));
    directed.push_back(query_row(4, 5, 1, 2, 5, 0));
    // Tie between the minimum and five: the smaller value wins.
    directed.push_back(query_row(1, 5, 1, 2, 32'sh8000_0000, 0));
    directed.push_back(query_row(Depth, Depth, 1, 1, 7, 0));
    // Start of zero and end beyond the depth raise the error flag.
    directed.push_back(query_row(0, 3, 1, 0, 0, 1));
    directed.push_back(query_row(1, Depth + 1, 1, 0, 0, 1));
    directed.push_back(query_row(0, 8191, 1, 0, 0, 1));
    directed.push_back(query_row(8191, 8191, 1, 0, 0, 1));
    // Empty range: end before start.
    directed.push_back(query_row(3, 2, 1, 0, 0, 0));
    directed.push_back(query_row(8191, 1, 1, 0, 0, 0));
    directed.push_back(load_row(Depth - 1, -1));
    directed.push_back(query_row(Depth, Depth, 1, 1, -1, 0));
    directed.push_back(query_row(2, 5, 0, 0, 0, 0));
    foreach (directed[i]) offer_word(directed[i]);

    // Fill the low region so that random queries have data to scan.
    for (int a = 5; a < 64; a++) offer_word(load_row(a, pool_value()));

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 20) long_hold = 1'b1;
      if (n == 40) begin
        in_bus.valid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(posedge clk);
      end
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 3) == 0) begin
          r = load_row($urandom_range(0, Depth - 1), $urandom());
        end else begin
          r = load_row($urandom_range(0, 63), pool_value());
        end
      end else begin
        r = random_query();
      end
      offer_word(r);
    end
    in_bus.valid <= 1'b0;

    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS range_mode_query_core");
    end else begin
      $display("FAIL range_mode_query_core");
    end
    $finish;
  end

endmodule

FILE: range_mode_query_core.f
+incdir+src
src/rmq_pkg.sv
src/rmq_if.sv
src/rmq_ram.sv
src/range_mode_query_core.sv
tb/tb_top.sv
